// ===== hdl/faluc_pkg.sv =====
`timescale 1ns / 1ps
package faluc_pkg;

   // Operation codes carried on the func field.
   typedef enum logic [2:0] {
      FUNC_MUL_Q24_8  = 3'd0,
      FUNC_MUL_Q16_16 = 3'd1,
      FUNC_MUL_Q8_24  = 3'd2,
      FUNC_MUL_Q1_31  = 3'd3,
      FUNC_DIV_Q1_31  = 3'd4,
      FUNC_CVT_Q8_24  = 3'd5,
      FUNC_CVT_Q16_16 = 3'd6,
      FUNC_NONE       = 3'd7
   } func_type;

   localparam int unsigned DATA_W     = 32;
   localparam int unsigned QUO_W      = DATA_W - 1;
   localparam int unsigned DIV_STAGES = QUO_W;

   localparam logic [DATA_W-1:0] Q31_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] Q31_MIN = 32'h8000_0000;

   // Payload that moves down the pipeline with each request.
   typedef struct packed {
      func_type            func;
      logic [2*DATA_W-1:0] prod;
      logic [DATA_W-1:0]   rem;
      logic [DATA_W-1:0]   dvs;
      logic [QUO_W-1:0]    quo;
      logic                neg;
      logic                fixed;
      logic [DATA_W-1:0]   fixed_res;
      logic                fixed_err;
   } pipe_type;

endpackage

// ===== hdl/faluc_req_if.sv =====
`timescale 1ns / 1ps
interface faluc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [31:0] operand_a;
   logic [31:0] operand_b;

   modport source (output valid, func, operand_a, operand_b, input ready);
   modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface

// ===== hdl/faluc_rsp_if.sv =====
`timescale 1ns / 1ps
interface faluc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result;
   logic        error;

   modport source (output valid, result, error, input ready);
   modport sink   (input valid, result, error, output ready);
endinterface

// ===== hdl/faluc_prep.sv =====
`timescale 1ns / 1ps
module faluc_prep
   import faluc_pkg::*;
(
   input  logic [2:0]        func,
   input  logic [DATA_W-1:0] operand_a,
   input  logic [DATA_W-1:0] operand_b,
   output pipe_type          stage
);

   logic signed [2*DATA_W-1:0] prod;
   logic [DATA_W-1:0]          mag_a;
   logic [DATA_W-1:0]          mag_b;
   logic [DATA_W-1:0]          cvt_shift;
   logic                       cvt_rb;
   logic                       same_sign;

   // Full signed product, rounded in the last stage.
   assign prod = $signed(operand_a) * $signed(operand_b);

   assign mag_a     = operand_a[DATA_W-1] ? (~operand_a + 1'b1) : operand_a;
   assign mag_b     = operand_b[DATA_W-1] ? (~operand_b + 1'b1) : operand_b;
   assign same_sign = (operand_a[DATA_W-1] == operand_b[DATA_W-1]);

   // Decode the operation and settle every result known up front.
   always_comb begin
      stage           = '0;
      stage.func      = func_type'(func);
      stage.prod      = prod;
      cvt_shift       = '0;
      cvt_rb          = 1'b0;
      case (func_type'(func))
         FUNC_DIV_Q1_31: begin
            if ($signed(operand_a) >= $signed(operand_b)) begin
               stage.fixed     = 1'b1;
               stage.fixed_res = Q31_MAX;
            end else if (operand_b == '0) begin
               stage.fixed     = 1'b1;
               stage.fixed_res = Q31_MIN;
               stage.fixed_err = 1'b1;
            end else if (same_sign && mag_a >= mag_b) begin
               stage.fixed     = 1'b1;
               stage.fixed_res = Q31_MAX;
               stage.fixed_err = 1'b1;
            end else if (!same_sign && mag_a >= mag_b) begin
               // An exact quotient of minus one fits; anything larger does not.
               stage.fixed     = 1'b1;
               stage.fixed_res = Q31_MIN;
               stage.fixed_err = (mag_a != mag_b);
            end else begin
               stage.rem = mag_a;
               stage.dvs = mag_b;
               stage.neg = !same_sign;
            end
         end
         FUNC_CVT_Q8_24, FUNC_CVT_Q16_16: begin
            if (func_type'(func) == FUNC_CVT_Q8_24) begin
               cvt_shift = DATA_W'($signed(operand_b) >>> 16);
               cvt_rb    = operand_b[15];
            end else begin
               cvt_shift = DATA_W'($signed(operand_b) >>> 8);
               cvt_rb    = operand_b[7];
            end
            stage.fixed = 1'b1;
            if (operand_b[DATA_W-1]) begin
               stage.fixed_res = cvt_rb ? cvt_shift : cvt_shift - 1'b1;
            end else begin
               stage.fixed_res = cvt_rb ? cvt_shift + 1'b1 : cvt_shift;
            end
         end
         FUNC_NONE: begin
            stage.fixed = 1'b1;
         end
         default: begin
            stage.fixed = 1'b0;
         end
      endcase
   end

endmodule

// ===== hdl/faluc_div_step.sv =====
`timescale 1ns / 1ps
module faluc_div_step
   import faluc_pkg::*;
(
   input  pipe_type stage_in,
   output pipe_type stage_out
);

   logic [DATA_W:0] rem2;
   logic            fits;

   // One restoring step: double the remainder and try to take the divisor.
   assign rem2 = {stage_in.rem, 1'b0};
   assign fits = (rem2 >= {1'b0, stage_in.dvs});

   always_comb begin
      stage_out     = stage_in;
      stage_out.rem = fits ? DATA_W'(rem2 - {1'b0, stage_in.dvs}) : DATA_W'(rem2);
      stage_out.quo = {stage_in.quo[QUO_W-2:0], fits};
   end

endmodule

// ===== hdl/faluc_finish.sv =====
`timescale 1ns / 1ps
module faluc_finish
   import faluc_pkg::*;
(
   input  pipe_type          stage,
   output logic [DATA_W-1:0] result,
   output logic              error
);

   logic [DATA_W-1:0] cut;
   logic [DATA_W-1:0] rnd;
   logic              rb;
   logic [DATA_W-1:0] quo_ext;

   // Pick the product window and its round bit.
   always_comb begin
      case (stage.func)
         FUNC_MUL_Q24_8: begin
            cut = stage.prod[39:8];
            rb  = stage.prod[7];
         end
         FUNC_MUL_Q16_16: begin
            cut = stage.prod[47:16];
            rb  = stage.prod[15];
         end
         FUNC_MUL_Q8_24: begin
            cut = stage.prod[55:24];
            rb  = stage.prod[23];
         end
         default: begin
            cut = stage.prod[62:31];
            rb  = stage.prod[30];
         end
      endcase
   end

   // Round away on the round bit, then fold minus one onto zero.
   always_comb begin
      if (cut[DATA_W-1]) begin
         rnd = rb ? cut : cut - 1'b1;
      end else begin
         rnd = rb ? cut + 1'b1 : cut;
      end
      if (rnd == '1) begin
         rnd = '0;
      end
   end

   assign quo_ext = {1'b0, stage.quo};

   always_comb begin
      if (stage.fixed) begin
         result = stage.fixed_res;
         error  = stage.fixed_err;
      end else if (stage.func == FUNC_DIV_Q1_31) begin
         result = stage.neg ? (~quo_ext + 1'b1) : quo_ext;
         error  = 1'b0;
      end else begin
         result = rnd;
         error  = 1'b0;
      end
   end

endmodule

// ===== hdl/fixed_point_mul_div_convert_alu_core.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Payload                         | Handshake
// req_ch   | in        | func, operand_a, operand_b      | valid / ready
// rsp_ch   | out       | result, error                   | valid / ready
//
// Each request passes through 33 register stages on its way to a valid response:
// decode and the 32x32 multiply, 31 restoring divider stages (one quotient bit each),
// and the rounding and output stage. One request is accepted per cycle unless the
// pipeline is stalled. Reset is synchronous and clears valid bits only.
// Each stage holds while the stage after it is full and stalled; empty stages
// still fill, so requests are taken while a response waits.
module fixed_point_mul_div_convert_alu_core
   import faluc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   faluc_req_if.sink    req_ch,
   faluc_rsp_if.source  rsp_ch
);

   localparam int unsigned DEPTH = DIV_STAGES + 1;

   pipe_type          stage_ff [DEPTH];
   pipe_type          stage_in [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [DEPTH-1:0]  advance;
   logic              out_advance;
   logic [DATA_W-1:0] result_in;
   logic              error_in;
   logic [DATA_W-1:0] result_ff;
   logic              error_ff;
   logic              rsp_valid_ff;

   // Stall chain: a stage moves when empty or when its successor moves.
   assign out_advance = !rsp_valid_ff || rsp_ch.ready;
   always_comb begin
      advance[DEPTH-1] = !valid_ff[DEPTH-1] || out_advance;
      for (int i = DEPTH - 2; i >= 0; i--) begin
         advance[i] = !valid_ff[i] || advance[i+1];
      end
   end

   assign req_ch.ready = advance[0];

   faluc_prep u_prep (
      .func      (req_ch.func),
      .operand_a (req_ch.operand_a),
      .operand_b (req_ch.operand_b),
      .stage     (stage_in[0])
   );

   // Divider stages.
   for (genvar g = 1; g < DEPTH; g++) begin : g_div
      faluc_div_step u_step (
         .stage_in  (stage_ff[g-1]),
         .stage_out (stage_in[g])
      );
   end

   faluc_finish u_finish (
      .stage  (stage_ff[DEPTH-1]),
      .result (result_in),
      .error  (error_in)
   );

   // Pipeline registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff[0] <= advance[0] ? req_ch.valid : valid_ff[0];
         for (int i = 1; i < DEPTH; i++) begin
            if (advance[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if (advance[i]) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_advance) begin
         rsp_valid_ff <= valid_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_advance) begin
         result_ff <= result_in;
         error_ff  <= error_in;
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.result = result_ff;
   assign rsp_ch.error  = error_ff;

   // An accepted request lands in the first stage.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> valid_ff[0])
      else $error("accepted request did not enter the pipeline");

   // A full first stage that cannot move keeps its payload.
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] && !advance[0] |=> valid_ff[0] && $stable(stage_ff[0]))
      else $error("stalled stage lost its request");

   // The last stage hands over to the output when it may move.
   a_last_moves: assert property (@(posedge clock) disable iff (reset)
      valid_ff[DEPTH-1] && out_advance |=> rsp_valid_ff)
      else $error("last stage dropped a request");

   // An error response is always saturated.
   a_error_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && error_ff |-> result_ff == Q31_MAX || result_ff == Q31_MIN)
      else $error("error response not saturated");

endmodule

// ===== dv/tb_fixed_point_mul_div_convert_alu_core.sv =====
`timescale 1ns / 1ps
module tb_fixed_point_mul_div_convert_alu_core
   import faluc_pkg::*;
();

   // One expected response of the ALU.
   typedef struct {
      logic [31:0] result;
      logic        error;
   } alu_rsp_type;

   // Round a multiply product the way the block does.
   function automatic logic [31:0] mul_rounded(logic [31:0] a, logic [31:0] b, int sh);
      logic signed [63:0] prod;
      logic [31:0]        r;
      logic               rb;
      prod = $signed(a) * $signed(b);
      r = 32'(prod >> sh);
      rb = prod[sh-1];
      if (r[31]) begin
         if (!rb) r = r - 32'd1;
      end else begin
         if (rb) r = r + 32'd1;
      end
      if (r == 32'hFFFF_FFFF) r = '0;
      return r;
   endfunction

   // Narrow a wider fixed-point format to Q24.8 with the same rounding rule.
   function automatic logic [31:0] cvt_rounded(logic [31:0] v, int sh);
      logic [31:0] r;
      logic        rb;
      r = 32'($signed(v) >>> sh);
      rb = v[sh-1];
      if (v[31]) begin
         if (!rb) r = r - 32'd1;
      end else begin
         if (rb) r = r + 32'd1;
      end
      return r;
   endfunction

   // Q1.31 quotient with saturation.
   function automatic alu_rsp_type div_q31(logic [31:0] a, logic [31:0] b);
      alu_rsp_type        o;
      longint             sa, sb, q;
      sa = $signed(a);
      sb = $signed(b);
      o.error = 1'b0;
      if (sa >= sb) begin
         o.result = Q31_MAX;
      end else if (sb == 0) begin
         o.result = Q31_MIN;
         o.error = 1'b1;
      end else begin
         q = (sa * 64'sd2147483648) / sb;
         if (q > 64'sd2147483647) begin
            o.result = Q31_MAX;
            o.error = 1'b1;
         end else if (q < -64'sd2147483648) begin
            o.result = Q31_MIN;
            o.error = 1'b1;
         end else begin
            o.result = q[31:0];
         end
      end
      return o;
   endfunction

   function automatic alu_rsp_type alu_predict(func_type f, logic [31:0] a, logic [31:0] b);
      alu_rsp_type o;
      o.result = '0;
      o.error = 1'b0;
      case (f)
         FUNC_MUL_Q24_8:  o.result = mul_rounded(a, b, 8);
         FUNC_MUL_Q16_16: o.result = mul_rounded(a, b, 16);
         FUNC_MUL_Q8_24:  o.result = mul_rounded(a, b, 24);
         FUNC_MUL_Q1_31:  o.result = mul_rounded(a, b, 31);
         FUNC_DIV_Q1_31:  o = div_q31(a, b);
         FUNC_CVT_Q8_24:  o.result = cvt_rounded(b, 16);
         FUNC_CVT_Q16_16: o.result = cvt_rounded(b, 8);
         default: o.result = '0;
      endcase
      return o;
   endfunction

   // Keeps the responses still owed by the block, oldest first.
   class alu_scoreboard;
      alu_rsp_type pending[$];
      int          errors;

      function void note_request(func_type f, logic [31:0] a, logic [31:0] b);
         pending.push_back(alu_predict(f, a, b));
      endfunction

      function void check_response(logic [31:0] res, logic err);
         alu_rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response result=%h error=%b", $time, res, err);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (res !== e.result) begin
            $display("%0t: result expected %h actual %h", $time, e.result, res);
            errors++;
         end
         if (err !== e.error) begin
            $display("%0t: error expected %b actual %b", $time, e.error, err);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   logic hold_off = 0;
   int   cycles = 0;
   event hold_go;

   faluc_req_if req_ch ();
   faluc_rsp_if rsp_ch ();
   alu_scoreboard sb = new();

   fixed_point_mul_div_convert_alu_core dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source));

   always #2 clock = ~clock;

   initial begin
      req_ch.valid = 0;
      req_ch.func = 0;
      req_ch.operand_a = 0;
      req_ch.operand_b = 0;
      rsp_ch.ready = 0;
   end

   // Long receiver hold-off, counted in cycles in its own process.
   initial begin
      @(hold_go);
      hold_off = 1'b1;
      repeat (200) @(posedge clock);
      hold_off = 1'b0;
   end

   // Response side: random stalls, the long hold-off when asked, and checking.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.result, rsp_ch.error);
         if (hold_off) begin
            rsp_ch.ready <= 0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("FAIL");
         $finish;
      end
   end

   // Offer one request and hold it until it is taken.
   task automatic send_request(func_type f, logic [31:0] a, logic [31:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.func <= f;
      req_ch.operand_a <= a;
      req_ch.operand_b <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_request(f, a, b);
   endtask

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(5))
         0: return 32'h8000_0000 >> $urandom_range(31);
         1: return $urandom_range(65535) << $urandom_range(16);
         2: return -($urandom_range(65535) << $urandom_range(16));
         3: return $urandom_range(3) == 0 ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random(int n);
      logic [31:0] a, b;
      for (int i = 0; i < n; i++) begin
         a = rand_operand();
         b = rand_operand();
         if ($urandom_range(19) == 0) b = 0;
         if ($urandom_range(9) == 0) b = ~a + $urandom_range(3);
         send_request(func_type'($urandom_range(7)), a, b);
      end
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [31:0] edges[5];
      edges = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0100};
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: every operation on extreme operands and the divide corners.
      for (int f = 0; f < 8; f++)
         send_request(func_type'(f), edges[f % 5], edges[(f + 2) % 5]);
      send_request(FUNC_DIV_Q1_31, 32'h0000_0100, 32'h0000_0100);
      send_request(FUNC_DIV_Q1_31, 32'hFFFF_FF00, 32'h0);
      send_request(FUNC_DIV_Q1_31, 32'h8000_0000, 32'h0000_0001);
      send_request(FUNC_DIV_Q1_31, 32'hFFFF_FFFF, 32'h0000_0001);
      send_request(FUNC_DIV_Q1_31, 32'h0000_0080, 32'h0000_0100);
      send_request(FUNC_DIV_Q1_31, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(FUNC_MUL_Q24_8, 32'hFFFF_FFFF, 32'h0000_0001);
      send_request(FUNC_MUL_Q1_31, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(FUNC_MUL_Q8_24, 32'h8000_0000, 32'h8000_0000);
      send_request(FUNC_CVT_Q8_24, 32'hFFFF_8000, 32'h0);
      send_request(FUNC_CVT_Q8_24, 32'h0, 32'hFFFF_7FFF);
      send_request(FUNC_CVT_Q16_16, 32'h0, 32'h0000_0080);
      send_request(FUNC_CVT_Q16_16, 32'h0, 32'h8000_0000);
      req_ch.valid <= 0;
      drain();

      // Random phases with differing idle and stall rates.
      send_random(400);
      send_idle_pct = 83;
      send_random(250);
      send_idle_pct = 0;
      recv_stall_pct = 83;
      send_random(250);
      send_idle_pct = 20;
      recv_stall_pct = 20;
      send_random(300);

      // Long receiver hold-off so the pipeline fills and stalls the input.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      -> hold_go;
      send_random(200);
      req_ch.valid <= 0;
      drain();
      send_random(200);
      req_ch.valid <= 0;
      drain();
      repeat (40) @(posedge clock);

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
